FILE: hdl/grid_index_to_geo_position_core_macros.svh
// Assertion macros for the grid index to geographic position core.
// Included by the modules that carry concurrent checks; needs no package.
// Simulation builds see the checks, synthesis builds see empty bodies.
`ifndef GRID_INDEX_TO_GEO_POSITION_CORE_MACROS_SVH
`define GRID_INDEX_TO_GEO_POSITION_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define GIG_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define GIG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define GIG_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define GIG_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/gig_pkg.sv
// Shared types, constants and the Q16 interpolation function of the core.
// Used by every module of the block but gig_ram; depends on nothing else.
package gig_pkg;

    localparam int GIG_MAX_ROWS   = 64;
    localparam int GIG_MAX_COLS   = 64;
    localparam int GIG_MAX_LEVELS = 32;

    localparam logic [6:0] ROWS_RESET   = 7'd64;
    localparam logic [6:0] COLS_RESET   = 7'd64;
    localparam logic [5:0] LEVELS_RESET = 6'd32;

    // Command codes carried on the slave side tuser.
    localparam logic [2:0] CMD_WR_LON   = 3'd0;
    localparam logic [2:0] CMD_WR_LAT   = 3'd1;
    localparam logic [2:0] CMD_WR_BATHY = 3'd2;
    localparam logic [2:0] CMD_WR_LEVEL = 3'd3;
    localparam logic [2:0] CMD_CONVERT  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROWS   = 2'd0;
    localparam logic [1:0] CFG_COLS   = 2'd1;
    localparam logic [1:0] CFG_LEVELS = 2'd2;

    localparam int GRID_W  = 32;
    localparam int SIGMA_W = 18;
    localparam int FRAC_W  = 16;

    typedef struct packed {
        logic valid;
        logic convert;
        logic outside;
        logic wr_lon;
        logic wr_lat;
        logic wr_bathy;
        logic wr_level;
    } gig_ctrl_t;

    typedef struct packed {
        logic                valid;
        logic                outside;
        logic [GRID_W-1:0]   lon;
        logic [GRID_W-1:0]   lat;
        logic [GRID_W-1:0]   h;
        logic [SIGMA_W-1:0]  s0;
        logic [SIGMA_W-1:0]  s1;
        logic [FRAC_W-1:0]   kf;
    } gig_depth_in_t;

    // a + round_half_up((b - a) * f / 2^16), which equals the weighted sum form.
    function automatic logic signed [31:0] lerp_q16(input logic signed [31:0] a,
                                                    input logic signed [31:0] b,
                                                    input logic [15:0] f);
        logic signed [32:0] diff;
        logic signed [49:0] prod;
        logic signed [49:0] step;
        diff = 33'(b) - 33'(a);
        prod = 50'(diff) * 50'(signed'({1'b0, f}));
        step = (prod + 50'sd32768) >>> 16;
        return 32'(50'(a) + step);
    endfunction

endpackage

FILE: hdl/grid_index_to_geo_position_core.sv
// Top level of the grid index to geographic position core.
// Depends on gig_pkg, gig_ram, gig_decode, gig_lane, gig_depth and the macros.
//
// Use: the slave side takes one word per cycle while s_tready is high. s_tuser carries the command;
// table writes (longitude, latitude, bathymetry, sigma level) fill the
// memories, and a convert word yields exactly one result word on the master
// side: interpolated longitude and latitude (Q22 degrees) and depth (Q16 m).
// Writes and unknown commands produce no result. A convert word that lands
// outside the grid returns zero fields with m_tuser set.
// The configuration channel (cfg_valid, cfg_index, cfg_data) is always ready
// and sets the row, column and level extents; write it only while idle.
// Throughput is one word per cycle. A convert accepted on the slave side
// passes the decode stage, the registered memory read, two interpolation
// stages and four depth stages, in that order, before it shows on m_tvalid.
// All stages move together; while m_tvalid is high and m_tready low the whole
// pipeline holds, s_tready drops and nothing is lost or repeated.
// Reset clears the valid bits and sets the extents to 64 rows, 64 columns and
// 32 levels. Table contents are undefined until written; there is no
// clearing pass.
`include "grid_index_to_geo_position_core_macros.svh"

module grid_index_to_geo_position_core
    import gig_pkg::*;
#(
    parameter int MAX_ROWS   = GIG_MAX_ROWS,
    parameter int MAX_COLS   = GIG_MAX_COLS,
    parameter int MAX_LEVELS = GIG_MAX_LEVELS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // row_index[5:0], col_index[11:6], level_index[16:12], table_value[48:17],
    // level_pos[70:49], row_pos[102:71], col_pos[134:103], zero pad[135]
    input  logic [135:0]  s_tdata,
    // command[2:0]
    input  logic [2:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // lon_out[31:0], lat_out[63:32], depth_out[95:64]
    output logic [95:0]   m_tdata,
    // outside_grid[0]
    output logic          m_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [6:0]    cfg_data
);

    localparam int RW         = $clog2(MAX_ROWS);
    localparam int CW         = $clog2(MAX_COLS);
    localparam int LW         = $clog2(MAX_LEVELS);
    localparam int HALF_ROWS  = (MAX_ROWS + 1) / 2;
    localparam int HALF_COLS  = (MAX_COLS + 1) / 2;
    localparam int BANK_DEPTH = HALF_ROWS * HALF_COLS;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic [6:0] rows_reg;
    logic [6:0] cols_reg;
    logic [5:0] levels_reg;

    logic ce;

    gig_ctrl_t      a_ctrl;
    logic [RW-1:0]  a_row;
    logic [CW-1:0]  a_col;
    logic [15:0]    a_rf, a_cf, a_kf;
    logic [LW-1:0]  a_slot, a_below;
    logic [31:0]    a_value;

    logic [AW-1:0]  bank_addr [4];
    logic [3:0]     bank_sel;
    logic [2:0]     grid_wr;

    logic [3:0][31:0] bank_rd [3];
    logic [17:0]      s0_rd, s1_rd;
    logic [31:0]      lane_val [3];

    // Stage B (memory data), C and D side information.
    logic        b_valid_reg, c_valid_reg, d_valid_reg;
    logic        b_out_reg, c_out_reg, d_out_reg;
    logic        b_r0p_reg, b_c0p_reg;
    logic [15:0] b_rf_reg, b_cf_reg, b_kf_reg, c_kf_reg, d_kf_reg;
    logic [17:0] c_s0_reg, c_s1_reg, d_s0_reg, d_s1_reg;

    gig_depth_in_t depth_in;

    // The pipeline advances whenever the output register is free or drained.
    assign ce        = m_tready || !m_tvalid;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= ROWS_RESET;
            cols_reg   <= COLS_RESET;
            levels_reg <= LEVELS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROWS:   rows_reg   <= cfg_data;
                CFG_COLS:   cols_reg   <= cfg_data;
                CFG_LEVELS: levels_reg <= cfg_data[5:0];
                default:    ;
            endcase
        end
    end

    gig_decode #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .ce          (ce),
        .accept      (s_tvalid && s_tready),
        .command     (s_tuser),
        .row_index   (s_tdata[5:0]),
        .col_index   (s_tdata[11:6]),
        .level_index (s_tdata[16:12]),
        .table_value (s_tdata[48:17]),
        .level_pos   (s_tdata[70:49]),
        .row_pos     (s_tdata[102:71]),
        .col_pos     (s_tdata[134:103]),
        .rows_cfg    (rows_reg),
        .cols_cfg    (cols_reg),
        .levels_cfg  (levels_reg),
        .ctrl        (a_ctrl),
        .row_q       (a_row),
        .col_q       (a_col),
        .rf_q        (a_rf),
        .cf_q        (a_cf),
        .slot_q      (a_slot),
        .below_q     (a_below),
        .kf_q        (a_kf),
        .value_q     (a_value)
    );

    // Each grid is split into four banks by row and column parity, so the
    // four corners of a cell always sit in different banks. Bank {p, q}
    // serves the corner row of parity p and the corner column of parity q;
    // a write lands in the bank of its own parity at the same address.
    assign grid_wr[0] = ce && a_ctrl.valid && a_ctrl.wr_lon;
    assign grid_wr[1] = ce && a_ctrl.valid && a_ctrl.wr_lat;
    assign grid_wr[2] = ce && a_ctrl.valid && a_ctrl.wr_bathy;

    for (genvar k = 0; k < 4; k++)
    begin : g_bank_addr
        logic [RW-1:0] rp;
        logic [CW-1:0] cp;
        assign rp = (a_row[0] == 1'(k >> 1)) ? a_row : a_row + RW'(1);
        assign cp = (a_col[0] == 1'(k)) ? a_col : a_col + CW'(1);
        assign bank_addr[k] = AW'(32'(rp >> 1) * HALF_COLS + 32'(cp >> 1));
        assign bank_sel[k]  = ({a_row[0], a_col[0]} == 2'(k));
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_grid
        for (genvar k = 0; k < 4; k++)
        begin : g_bank
            gig_ram #(
                .WIDTH (GRID_W),
                .DEPTH (BANK_DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (grid_wr[g] && bank_sel[k]),
                .waddr (bank_addr[k]),
                .wdata (a_value),
                .re    (ce),
                .raddr (bank_addr[k]),
                .rdata (bank_rd[g][k])
            );
        end

        gig_lane u_lane (
            .clk       (clk),
            .ce        (ce),
            .bank_data (bank_rd[g]),
            .r0p       (b_r0p_reg),
            .c0p       (b_c0p_reg),
            .rf        (b_rf_reg),
            .cf        (b_cf_reg),
            .value     (lane_val[g])
        );
    end

    // Two copies of the level table give the slot and the slot below in
    // the same cycle.
    gig_ram #(
        .WIDTH (SIGMA_W),
        .DEPTH (MAX_LEVELS)
    ) u_level_upper (
        .clk   (clk),
        .we    (ce && a_ctrl.valid && a_ctrl.wr_level),
        .waddr (a_slot),
        .wdata (a_value[17:0]),
        .re    (ce),
        .raddr (a_slot),
        .rdata (s0_rd)
    );

    gig_ram #(
        .WIDTH (SIGMA_W),
        .DEPTH (MAX_LEVELS)
    ) u_level_lower (
        .clk   (clk),
        .we    (ce && a_ctrl.valid && a_ctrl.wr_level),
        .waddr (a_slot),
        .wdata (a_value[17:0]),
        .re    (ce),
        .raddr (a_below),
        .rdata (s1_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            b_valid_reg <= a_ctrl.valid && a_ctrl.convert;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            b_out_reg <= a_ctrl.outside;
            b_r0p_reg <= a_row[0];
            b_c0p_reg <= a_col[0];
            b_rf_reg  <= a_rf;
            b_cf_reg  <= a_cf;
            b_kf_reg  <= a_kf;

            c_out_reg <= b_out_reg;
            c_kf_reg  <= b_kf_reg;
            c_s0_reg  <= s0_rd;
            c_s1_reg  <= s1_rd;

            d_out_reg <= c_out_reg;
            d_kf_reg  <= c_kf_reg;
            d_s0_reg  <= c_s0_reg;
            d_s1_reg  <= c_s1_reg;
        end
    end

    always_comb
    begin
        depth_in.valid   = d_valid_reg;
        depth_in.outside = d_out_reg;
        depth_in.lon     = lane_val[0];
        depth_in.lat     = lane_val[1];
        depth_in.h       = lane_val[2];
        depth_in.s0      = d_s0_reg;
        depth_in.s1      = d_s1_reg;
        depth_in.kf      = d_kf_reg;
    end

    gig_depth u_depth (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (ce),
        .din      (depth_in),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `GIG_ASSERT_NEXT(a_write_no_result, clk, rst_n, ce && a_ctrl.valid && !a_ctrl.convert, !b_valid_reg)
    `GIG_ASSERT_NEXT(a_convert_moves, clk, rst_n, ce && a_ctrl.valid && a_ctrl.convert, b_valid_reg)

endmodule

FILE: hdl/gig_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Stand-alone; instantiated for every grid bank and the level table.
module gig_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/gig_decode.sv
// Input stage: decodes the command, splits row and column positions and
// works out the level slots. Depends on gig_pkg and the assertion macros.
`include "grid_index_to_geo_position_core_macros.svh"

module gig_decode
    import gig_pkg::*;
#(
    parameter int MAX_ROWS   = GIG_MAX_ROWS,
    parameter int MAX_COLS   = GIG_MAX_COLS,
    parameter int MAX_LEVELS = GIG_MAX_LEVELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ce,
    input  logic                            accept,
    input  logic [2:0]                      command,
    input  logic [5:0]                      row_index,
    input  logic [5:0]                      col_index,
    input  logic [4:0]                      level_index,
    input  logic [31:0]                     table_value,
    input  logic [21:0]                     level_pos,
    input  logic [31:0]                     row_pos,
    input  logic [31:0]                     col_pos,
    input  logic [6:0]                      rows_cfg,
    input  logic [6:0]                      cols_cfg,
    input  logic [5:0]                      levels_cfg,
    output gig_ctrl_t                       ctrl,
    output logic [$clog2(MAX_ROWS)-1:0]     row_q,
    output logic [$clog2(MAX_COLS)-1:0]     col_q,
    output logic [15:0]                     rf_q,
    output logic [15:0]                     cf_q,
    output logic [$clog2(MAX_LEVELS)-1:0]   slot_q,
    output logic [$clog2(MAX_LEVELS)-1:0]   below_q,
    output logic [15:0]                     kf_q,
    output logic [31:0]                     value_q
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int LW  = $clog2(MAX_LEVELS);
    localparam int LVW = $clog2(MAX_LEVELS + 1);

    gig_ctrl_t          ctrl_reg,  ctrl_next;
    logic [RW-1:0]      row_reg,   row_next;
    logic [CW-1:0]      col_reg,   col_next;
    logic [LW-1:0]      slot_reg,  slot_next;
    logic [LW-1:0]      below_reg, below_next;
    logic [15:0]        rf_reg, cf_reg, kf_reg;
    logic [31:0]        value_reg;

    logic [16:0]        row_ext, col_ext, row_whole, col_whole;
    logic               row_bad, col_bad, idx_ok, is_conv;
    logic [LVW-1:0]     lev;
    logic [21:0]        lmag;
    logic [22:0]        cap, lmag_c;
    logic [6:0]         slot_v;

    always_comb
    begin
        row_ext   = (32'(rows_cfg) > MAX_ROWS) ? 17'(MAX_ROWS) : 17'(rows_cfg);
        col_ext   = (32'(cols_cfg) > MAX_COLS) ? 17'(MAX_COLS) : 17'(cols_cfg);
        row_whole = {1'b0, row_pos[31:16]};
        col_whole = {1'b0, col_pos[31:16]};
        // A nonzero fraction on the last row or column has no neighbour.
        row_bad = row_pos[31] || (row_whole >= row_ext) ||
                  ((row_whole + 17'd1 == row_ext) && (row_pos[15:0] != 16'd0));
        col_bad = col_pos[31] || (col_whole >= col_ext) ||
                  ((col_whole + 17'd1 == col_ext) && (col_pos[15:0] != 16'd0));

        if (32'(levels_cfg) > MAX_LEVELS)
        begin
            lev = LVW'(MAX_LEVELS);
        end
        else if (levels_cfg == 6'd0)
        begin
            lev = LVW'(1);
        end
        else
        begin
            lev = LVW'(levels_cfg);
        end
        lmag   = level_pos[21] ? 22'(-signed'(level_pos)) : 22'd0;
        cap    = 23'((32'(lev) - 32'd1) << 16);
        lmag_c = ({1'b0, lmag} > cap) ? cap : {1'b0, lmag};
        slot_v = lmag_c[22:16];

        is_conv = (command == CMD_CONVERT);
        idx_ok  = (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);

        ctrl_next          = '0;
        ctrl_next.valid    = accept;
        ctrl_next.convert  = is_conv;
        ctrl_next.outside  = is_conv && (row_bad || col_bad);
        ctrl_next.wr_lon   = (command == CMD_WR_LON)   && idx_ok;
        ctrl_next.wr_lat   = (command == CMD_WR_LAT)   && idx_ok;
        ctrl_next.wr_bathy = (command == CMD_WR_BATHY) && idx_ok;
        ctrl_next.wr_level = (command == CMD_WR_LEVEL) && (32'(level_index) < MAX_LEVELS);

        row_next  = is_conv ? RW'(row_whole) : RW'(row_index);
        col_next  = is_conv ? CW'(col_whole) : CW'(col_index);
        slot_next = is_conv ? LW'(slot_v) : LW'(level_index);
        // The slot under the bottom one is clamped to the bottom slot.
        below_next = ((32'(slot_v) + 32'd1) < 32'(lev)) ? LW'(32'(slot_v) + 32'd1)
                                                          : LW'(32'(lev) - 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (ce)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            slot_reg  <= slot_next;
            below_reg <= below_next;
            rf_reg    <= row_pos[15:0];
            cf_reg    <= col_pos[15:0];
            kf_reg    <= lmag_c[15:0];
            value_reg <= table_value;
        end
    end

    assign ctrl    = ctrl_reg;
    assign row_q   = row_reg;
    assign col_q   = col_reg;
    assign slot_q  = slot_reg;
    assign below_q = below_reg;
    assign rf_q    = rf_reg;
    assign cf_q    = cf_reg;
    assign kf_q    = kf_reg;
    assign value_q = value_reg;

    `GIG_ASSERT_IMPLY(a_outside_only_convert, clk, rst_n, ctrl_reg.outside, ctrl_reg.convert)

endmodule

FILE: hdl/gig_lane.sv
// One bilinear lane: sorts four bank words into corners, interpolates
// along columns, then along rows. Depends on gig_pkg.
module gig_lane
    import gig_pkg::*;
(
    input  logic                 clk,
    input  logic                 ce,
    input  logic [3:0][31:0]     bank_data,
    input  logic                 r0p,
    input  logic                 c0p,
    input  logic [15:0]          rf,
    input  logic [15:0]          cf,
    output logic [31:0]          value
);

    logic [31:0] a00, a01, a10, a11, b01, b11, bot_eff;
    logic [31:0] top_reg, bot_reg, value_reg;
    logic [15:0] rf_reg;

    always_comb
    begin
        a00 = bank_data[{r0p, c0p}];
        a01 = bank_data[{r0p, ~c0p}];
        a10 = bank_data[{~r0p, c0p}];
        a11 = bank_data[{~r0p, ~c0p}];
        // With no fraction the neighbour carries no weight and may be unwritten.
        b01 = (cf == 16'd0) ? a00 : a01;
        b11 = (cf == 16'd0) ? a10 : a11;
        bot_eff = (rf_reg == 16'd0) ? top_reg : bot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            top_reg   <= lerp_q16(a00, b01, cf);
            bot_reg   <= lerp_q16(a10, b11, cf);
            rf_reg    <= rf;
            value_reg <= lerp_q16(top_reg, bot_eff, rf_reg);
        end
    end

    assign value = value_reg;

endmodule

FILE: hdl/gig_depth.sv
// Depth pipeline and output register: sigma products, layer thickness
// share, rounding and saturation. Depends on gig_pkg and the assertion macros.
`include "grid_index_to_geo_position_core_macros.svh"

module gig_depth
    import gig_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ce,
    input  gig_depth_in_t  din,
    output logic           m_tvalid,
    output logic [95:0]    m_tdata,
    output logic           m_tuser
);

    // Stage E
    logic        e_valid_reg, e_out_reg;
    logic [31:0] e_lon_reg, e_lat_reg;
    logic [48:0] e_p0_reg, e_p1_reg;
    logic [15:0] e_kf_reg;
    // Stage F
    logic        f_valid_reg, f_out_reg;
    logic [31:0] f_lon_reg, f_lat_reg;
    logic [48:0] f_p0_reg, f_ad_reg;
    logic [15:0] f_kf_reg;
    // Stage G
    logic        g_valid_reg, g_out_reg;
    logic [31:0] g_lon_reg, g_lat_reg;
    logic [48:0] g_p0_reg, g_th_reg;
    logic [31:0] g_tl_reg;
    // Output
    logic        o_valid_reg, o_out_reg;
    logic [31:0] o_lon_reg, o_lat_reg, o_depth_reg;

    logic signed [49:0] prod0, prod1;
    logic [48:0]        p0_next, p1_next, ad_next;
    logic [50:0]        tot;
    logic [34:0]        dmag_w;
    logic [31:0]        dmag;

    always_comb
    begin
        prod0   = 50'(signed'(din.h)) * 50'(signed'(din.s0));
        prod1   = 50'(signed'(din.h)) * 50'(signed'(din.s1));
        p0_next = prod0[49] ? 49'(-prod0) : 49'(prod0);
        p1_next = prod1[49] ? 49'(-prod1) : 49'(prod1);
        ad_next = (e_p1_reg > e_p0_reg) ? (e_p1_reg - e_p0_reg) : (e_p0_reg - e_p1_reg);
        tot     = 51'(g_p0_reg) + 51'(g_th_reg) + 51'(g_tl_reg[31:16]) + 51'd32768;
        dmag_w  = tot[50:16];
        dmag    = (dmag_w > 35'h0_8000_0000) ? 32'h8000_0000 : dmag_w[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            e_valid_reg <= din.valid;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            o_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            e_out_reg   <= din.outside;
            e_lon_reg   <= din.lon;
            e_lat_reg   <= din.lat;
            e_p0_reg    <= p0_next;
            e_p1_reg    <= p1_next;
            e_kf_reg    <= din.kf;

            f_out_reg   <= e_out_reg;
            f_lon_reg   <= e_lon_reg;
            f_lat_reg   <= e_lat_reg;
            f_p0_reg    <= e_p0_reg;
            f_ad_reg    <= ad_next;
            f_kf_reg    <= e_kf_reg;

            g_out_reg   <= f_out_reg;
            g_lon_reg   <= f_lon_reg;
            g_lat_reg   <= f_lat_reg;
            g_p0_reg    <= f_p0_reg;
            g_th_reg    <= 49'(f_kf_reg * f_ad_reg[48:16]);
            g_tl_reg    <= 32'(f_kf_reg * f_ad_reg[15:0]);

            o_out_reg   <= g_out_reg;
            o_lon_reg   <= g_out_reg ? 32'd0 : g_lon_reg;
            o_lat_reg   <= g_out_reg ? 32'd0 : g_lat_reg;
            o_depth_reg <= g_out_reg ? 32'd0 : (32'd0 - dmag);
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {o_depth_reg, o_lat_reg, o_lon_reg};
    assign m_tuser  = o_out_reg;

    `GIG_ASSERT_IMPLY(a_outside_zero, clk, rst_n, o_valid_reg && o_out_reg, m_tdata == 96'd0)
    `GIG_ASSERT_IMPLY(a_depth_not_up, clk, rst_n, o_valid_reg, o_depth_reg[31] || (o_depth_reg == 32'd0))

endmodule
